// File: sv/payload_xor_fingerprint_dedup_defines.svh
// Assertion macros used by the port checker of the fingerprint dedup block.
`ifndef PAYLOAD_XOR_FINGERPRINT_DEDUP_DEFINES_SVH
`define PAYLOAD_XOR_FINGERPRINT_DEDUP_DEFINES_SVH

// Implication in the same cycle, disabled while reset is held.
`define PXD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the following cycle, disabled while reset is held.
`define PXD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication into the following cycle that is also checked while reset is held.
`define PXD_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/pxd_pkg.sv
// Types and constants shared by the fingerprint dedup block.
package pxd_pkg;

    // Fingerprint table geometry; the slot is the fingerprint's low bits,
    // so the depth is a power of two.
    localparam int TABLE_DEPTH = 16384;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    // Saturation point of the per-packet byte counter.
    localparam logic [15:0] POS_MAX = 16'hFFFF;

    // Reset values of the configuration registers.
    localparam logic [7:0]  HEADER_SKIP_RST = 8'd54;
    localparam logic [15:0] MIN_LEN_RST     = 16'd128;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SKIP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN     = 1'b1;

    // One input beat.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } pxd_in_t;

    // One result beat.
    typedef struct packed {
        logic [31:0] fingerprint;
        logic        was_hit;
        logic        was_stored;
        logic [31:0] total_hits;
        logic [31:0] total_used;
    } pxd_out_t;

    // Table lookup request issued at the end of a checked packet.
    typedef struct packed {
        logic        valid;
        logic [31:0] fp;
    } pxd_req_t;

endpackage

// File: sv/pxd_fold.sv
// Per-packet byte counter, header skip, word assembly and XOR fold.
module pxd_fold (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_accept,
    input  pxd_pkg::pxd_in_t in_data,
    input  logic [7:0]      header_skip,
    input  logic [15:0]     min_packet_len,
    output pxd_pkg::pxd_req_t req
);
    import pxd_pkg::*;

    logic [15:0] pos_reg;
    logic [15:0] pos_next;
    logic [23:0] partial_reg;
    logic [23:0] partial_next;
    logic [31:0] fold_reg;
    logic [31:0] fold_next;
    logic        absorb;
    logic [15:0] offset;
    logic [1:0]  lane;

    // Fold the current byte into the word being assembled.
    always_comb
    begin
        partial_next = partial_reg;
        fold_next    = fold_reg;
        absorb       = (pos_reg != POS_MAX) && (pos_reg >= {8'd0, header_skip});
        offset       = pos_reg - {8'd0, header_skip};
        lane         = offset[1:0];
        if (absorb)
        begin
            if (lane == 2'd3)
            begin
                fold_next    = fold_reg ^ {in_data.data_byte, partial_reg};
                partial_next = '0;
            end
            else
            begin
                partial_next = partial_reg | (24'(in_data.data_byte) << {lane, 3'b000});
            end
        end
        pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 16'd1;
    end

    // A final byte of a long enough packet asks for a table lookup.
    always_comb
    begin
        req.valid = in_accept && in_data.last_byte && (pos_next >= min_packet_len);
        req.fp    = fold_next;
    end

    // Packet state; it returns to zero at every packet end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            partial_reg <= '0;
            fold_reg    <= '0;
        end
        else if (in_accept)
        begin
            if (in_data.last_byte)
            begin
                pos_reg     <= '0;
                partial_reg <= '0;
                fold_reg    <= '0;
            end
            else
            begin
                pos_reg     <= pos_next;
                partial_reg <= partial_next;
                fold_reg    <= fold_next;
            end
        end
    end

endmodule

// File: sv/pxd_table.sv
// Fingerprint table memory with read-modify-write, counters and result register.
module pxd_table (
    input  logic              clk,
    input  logic              rst_n,
    input  pxd_pkg::pxd_req_t req,
    input  logic              out_stall,
    output logic              lookup_ready,
    output logic              out_valid,
    output pxd_pkg::pxd_out_t out_data
);
    import pxd_pkg::*;

    logic [31:0]      mem [TABLE_DEPTH];
    logic [31:0]      rdata_reg;

    logic             clr_busy_reg;
    logic [IDX_W-1:0] clr_idx_reg;

    logic             r_valid_reg;
    logic [31:0]      r_fp_reg;
    logic             r_fwd_reg;
    logic [31:0]      r_fwd_data_reg;

    logic             out_valid_reg;
    pxd_out_t         out_data_reg;
    logic [31:0]      hits_reg;
    logic [31:0]      used_reg;

    logic             resolve_go;
    logic [31:0]      slot_val;
    logic             slot_empty;
    logic             slot_hit;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [31:0]      wr_data;
    logic [IDX_W-1:0] rd_idx;
    logic [31:0]      hits_next;
    logic [31:0]      used_next;

    // Resolve the lookup whose read data is back, using the write of the
    // previous item when both touched the same slot in the same cycle.
    always_comb
    begin
        resolve_go = r_valid_reg && (!out_valid_reg || !out_stall);
        slot_val   = r_fwd_reg ? r_fwd_data_reg : rdata_reg;
        slot_empty = (slot_val == 32'd0);
        slot_hit   = !slot_empty && (slot_val == r_fp_reg);
        hits_next  = slot_hit ? hits_reg + 32'd1 : hits_reg;
        used_next  = used_reg + 32'd1;
    end

    // Write port: the clearing pass after reset, then stores of new fingerprints.
    always_comb
    begin
        wr_en   = clr_busy_reg || (resolve_go && slot_empty);
        wr_idx  = clr_busy_reg ? clr_idx_reg : r_fp_reg[IDX_W-1:0];
        wr_data = clr_busy_reg ? 32'd0 : r_fp_reg;
        rd_idx  = req.fp[IDX_W-1:0];
    end

    assign lookup_ready = !clr_busy_reg && (!r_valid_reg || resolve_go);

    // Table memory with one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (req.valid)
        begin
            rdata_reg <= mem[rd_idx];
        end
    end

    // Control state: clearing pass, lookup stage, result register, counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            r_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            hits_reg      <= '0;
            used_reg      <= '0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (req.valid)
            begin
                r_valid_reg <= 1'b1;
            end
            else if (resolve_go)
            begin
                r_valid_reg <= 1'b0;
            end
            if (resolve_go)
            begin
                out_valid_reg <= 1'b1;
                hits_reg      <= hits_next;
                used_reg      <= used_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the lookup stage and of the result register.
    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            r_fp_reg       <= req.fp;
            r_fwd_reg      <= wr_en && (wr_idx == rd_idx);
            r_fwd_data_reg <= wr_data;
        end
        if (resolve_go)
        begin
            out_data_reg.fingerprint <= r_fp_reg;
            out_data_reg.was_hit     <= slot_hit;
            out_data_reg.was_stored  <= slot_empty;
            out_data_reg.total_hits  <= hits_next;
            out_data_reg.total_used  <= used_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: sv/payload_xor_fingerprint_dedup.sv
// Packet payload XOR fingerprint with duplicate detection against a direct-mapped table.
//
// Input channel: one packet byte per beat, with last_byte on the final byte.
// The first header_skip bytes are skipped; the payload is packed into
// little-endian 32-bit words and every whole word is XOR-folded.
// Output channel: one result beat per packet of at least min_packet_len
// bytes, carrying the fold, hit and store flags and the running counts.
// Shorter packets give no beat. Configuration is a plain write port.
// Throughput: one byte per cycle while in_stall is low, packets back to back;
// the table sees one read and one write per cycle, with a forward path for a
// store to the same slot by the packet just before.
// Result path: the table read is registered when the final byte is accepted,
// and the result register loads from it once it is empty or its beat is taken.
// Reset: counters and packet state clear, and a clearing pass writes zero to
// all 16384 table slots; in_stall stays high until it ends.
// When the receiver stalls, the result register holds, one further lookup
// waits in the read stage, and then in_stall rises until the result is taken.
module payload_xor_fingerprint_dedup (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  pxd_pkg::pxd_in_t                     in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output pxd_pkg::pxd_out_t                    out_data,
    input  logic                                 cfg_we,
    input  logic [pxd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pxd_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import pxd_pkg::*;

    logic [7:0]  header_skip_reg;
    logic [15:0] min_len_reg;
    logic        lookup_ready;
    logic        in_accept;
    pxd_req_t    req;

    assign in_stall  = !lookup_ready;
    assign in_accept = in_valid && lookup_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_skip_reg <= HEADER_SKIP_RST;
            min_len_reg     <= MIN_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEADER_SKIP: header_skip_reg <= cfg_data[7:0];
                CFG_MIN_LEN:     min_len_reg     <= cfg_data;
            endcase
        end
    end

    pxd_fold u_fold (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_accept      (in_accept),
        .in_data        (in_data),
        .header_skip    (header_skip_reg),
        .min_packet_len (min_len_reg),
        .req            (req)
    );

    pxd_table u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .out_stall    (out_stall),
        .lookup_ready (lookup_ready),
        .out_valid    (out_valid),
        .out_data     (out_data)
    );

endmodule

// File: sv/pxd_checker.sv
// Port-level checker for the fingerprint dedup block and its bind.
`include "payload_xor_fingerprint_dedup_defines.svh"

module pxd_port_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input pxd_pkg::pxd_out_t out_data
);
    import pxd_pkg::*;

    logic        held;
    logic        taken;
    logic        both_flags;
    logic        zero_fp;
    logic [31:0] used_now;
    logic [31:0] used_inc;

    assign held       = out_valid && out_stall;
    assign taken      = out_valid && !out_stall;
    assign both_flags = out_data.was_hit && out_data.was_stored;
    assign zero_fp    = out_valid && (out_data.fingerprint == 32'd0);
    assign used_now   = out_data.total_used;
    assign used_inc   = out_data.total_used + 32'd1;

    // A stalled result beat holds.
    `PXD_ASSERT_NXT(a_out_hold, held, out_valid && $stable(out_data), "stalled result changed")

    // A slot is either found equal or found empty, never both.
    `PXD_ASSERT_IMP(a_hit_store_excl, out_valid, !both_flags, "hit and store together")

    // A zero fingerprint is never counted as a hit.
    `PXD_ASSERT_IMP(a_zero_no_hit, zero_fp, !out_data.was_hit, "zero fingerprint hit")

    // The beat that follows a taken beat counts the next checked packet.
    `PXD_ASSERT_NXT(a_used_step, taken, !out_valid || used_now == $past(used_inc), "count skipped")

    // Coming out of reset the table is being cleared and nothing is shown.
    `PXD_ASSERT_RST(a_reset_quiet, !rst_n, in_stall && !out_valid, "input taken during clear")

endmodule

bind payload_xor_fingerprint_dedup pxd_port_checker u_pxd_checker (.*);
